@@ design/mvws_pkg.sv @@
// Shared constants, codes, types and helpers for the multi-voice wave synthesizer.
// No dependencies; every other design file imports this package.
package mvws_pkg;

	localparam int VOICES       = 8;
	localparam int SINE_ENTRIES = 256;   // power of two
	localparam int PHASE_BITS   = 24;

	localparam int SINE_BITS = $clog2(SINE_ENTRIES);
	localparam int VIDX_W    = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam int SCALED_W  = 15;
	localparam int SUM_W     = 14 + $clog2(VOICES + 1);
	localparam int SAMPLE_W  = 17;

	localparam logic [15:0] LFSR_SEED = 16'hACE1;
	localparam logic [15:0] LFSR_TAPS = 16'hB400;

	// 0.2 in Q1.15 with round-half-up on the product
	localparam int GAIN_Q15  = 6554;
	localparam int SCALE_RND = 16384;

	// sine polynomial coefficients, Q14
	localparam int SIN_C1 = 25736;
	localparam int SIN_C2 = 10512;
	localparam int SIN_C3 = 1160;
	localparam int QTR_TURN = 16384;

	localparam int SAMPLE_MAX = 65535;
	localparam int SAMPLE_MIN = -65536;

	typedef enum logic [1:0] {
		OP_TICK = 2'd0,
		OP_SET  = 2'd1,
		OP_STOP = 2'd2
	} opcode_t;

	typedef enum logic [2:0] {
		WAVE_SINE     = 3'd0,
		WAVE_SQUARE   = 3'd1,
		WAVE_TRIANGLE = 3'd2,
		WAVE_SAW      = 3'd3,
		WAVE_NOISE    = 3'd4
	} wave_t;

	// one voice visit handed from the memory stage to the wave datapath
	typedef struct packed {
		logic                  valid;
		logic                  on;
		logic [2:0]            wave;
		logic [PHASE_BITS-1:0] phase;
	} voice_in_t;

	typedef struct packed {
		logic                       valid;
		logic signed [SCALED_W-1:0] scaled;
	} wave_out_t;

	// 0.24 step aligned to PHASE_BITS fraction bits, low bits dropped
	function automatic logic [PHASE_BITS-1:0] align_step(input logic [23:0] step);
		logic [55:0] w;
		w = {step, 32'b0};
		return PHASE_BITS'(w >> (56 - PHASE_BITS));
	endfunction

endpackage

@@ design/mvws_if.sv @@
// Valid/ready channel interfaces for the synthesizer: command words in, sample words out.
// Depends on mvws_pkg for field widths.
interface mvws_cmd_if
	import mvws_pkg::*;
	();
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [2:0]  voice_index;
	logic [23:0] phase_step;
	logic [2:0]  waveform;

	modport source (output valid, opcode, voice_index, phase_step, waveform, input ready);
	modport sink   (input valid, opcode, voice_index, phase_step, waveform, output ready);
endinterface

interface mvws_smp_if
	import mvws_pkg::*;
	();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] mixed_sample;

	modport source (output valid, mixed_sample, input ready);
	modport sink   (input valid, mixed_sample, output ready);
endinterface

@@ design/multi_voice_wave_synth.sv @@
// Top level of the multi-voice wave synthesizer: voice memories, sequencer, mixer.
// Depends on mvws_pkg, mvws_cmd_if/mvws_smp_if and mvws_wave.
//
// Usage
//   cmd (sink):  one command word per handshake. opcode tick produces one sample;
//                set loads step and waveform of voice_index and turns it on (the
//                phase is kept); stop turns it off. Set and stop to a voice index
//                not below VOICES, and the unused opcode, are dropped silently.
//   smp (source): one mixed_sample word per tick, signed, Q1.15 per voice,
//                 saturated to 17 bits.
// Timing
//   Set and stop do not leave IDLE; cmd.ready stays high for them.
//   A tick reads one voice per cycle from the voice memories: one read port
//   visit per voice, then the six-stage wave datapath and the accumulator.
//   cmd.ready stays low for the whole tick.
// Reset
//   All voices off, phases zero, noise LFSR at its seed, no sample pending.
// Backpressure
//   The sample sits in an output register. New set/stop words are taken while it
//   waits; a following tick runs and then holds its sum until smp drains.
module multi_voice_wave_synth
	import mvws_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	mvws_cmd_if.sink          cmd,
	mvws_smp_if.source        smp
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_DONE
	} state_t;

	state_t                     state_q;
	logic [VIDX_W-1:0]          cnt_q;
	logic signed [SUM_W-1:0]    acc_q;
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] out_sample_q;

	// voice memories: phase per voice, step+waveform per voice
	logic [PHASE_BITS-1:0]      phase_mem [VOICES];
	logic [PHASE_BITS+2:0]      cfg_mem   [VOICES];
	logic [VOICES-1:0]          pvld_q;   // phase entry written since reset
	logic [VOICES-1:0]          on_q;

	// read stage
	logic                       rd_v_s1;
	logic [VIDX_W-1:0]          idx_s1;
	logic                       on_s1;
	logic                       pvld_s1;
	logic [PHASE_BITS-1:0]      phase_s1;
	logic [PHASE_BITS+2:0]      cfg_s1;
	logic [PHASE_BITS-1:0]      cur_phase;
	logic                       ph_we;

	// command decode
	logic                       cmd_fire;
	logic                       cmd_vok;
	logic [VIDX_W-1:0]          cmd_idx;
	logic                       cfg_we;
	logic                       stop_we;

	voice_in_t                  vin;
	wave_out_t                  wout;
	logic                       wv_busy;
	logic signed [31:0]         acc_ext;

	assign cmd.ready = (state_q == ST_IDLE);
	assign cmd_fire  = cmd.valid && cmd.ready;
	assign cmd_vok   = (32'(cmd.voice_index) < VOICES);
	assign cmd_idx   = VIDX_W'(cmd.voice_index);
	assign cfg_we    = cmd_fire && cmd_vok && (cmd.opcode == OP_SET);
	assign stop_we   = cmd_fire && cmd_vok && (cmd.opcode == OP_STOP);

	// unwritten phase entries read as zero
	assign cur_phase = pvld_s1 ? phase_s1 : '0;
	assign ph_we     = rd_v_s1 && on_s1;

	// memories: read in RUN, phase written back in the cycle after the read (never the same entry)
	always_ff @(posedge clk) begin
		if (cfg_we) begin
			cfg_mem[cmd_idx] <= {align_step(cmd.phase_step), cmd.waveform};
		end
		if (ph_we) begin
			phase_mem[idx_s1] <= cur_phase + cfg_s1[PHASE_BITS+2:3];
		end
		phase_s1 <= phase_mem[cnt_q];
		cfg_s1   <= cfg_mem[cnt_q];
		idx_s1   <= cnt_q;
		on_s1    <= on_q[cnt_q];
		pvld_s1  <= pvld_q[cnt_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			on_q    <= '0;
			pvld_q  <= '0;
			rd_v_s1 <= 1'b0;
		end else begin
			rd_v_s1 <= (state_q == ST_RUN);
			if (cfg_we) begin
				on_q[cmd_idx] <= 1'b1;
			end
			if (stop_we) begin
				on_q[cmd_idx] <= 1'b0;
			end
			if (ph_we) begin
				pvld_q[idx_s1] <= 1'b1;
			end
		end
	end

	assign vin.valid = rd_v_s1;
	assign vin.on    = on_s1;
	assign vin.wave  = cfg_s1[2:0];
	assign vin.phase = cur_phase;

	mvws_wave u_wave (
		.clk    (clk),
		.arst_n (arst_n),
		.vin    (vin),
		.wout   (wout),
		.busy   (wv_busy)
	);

	assign acc_ext = 32'(acc_q);

	// sequencer, accumulator and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			acc_q        <= '0;
			out_valid_q  <= 1'b0;
			out_sample_q <= '0;
		end else begin
			// DONE reloads the output register itself
			if (smp.ready && (state_q != ST_DONE)) begin
				out_valid_q <= 1'b0;
			end
			if (wout.valid) begin
				acc_q <= acc_q + SUM_W'(wout.scaled);
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_fire && (cmd.opcode == OP_TICK)) begin
						cnt_q   <= '0;
						acc_q   <= '0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (cnt_q == VIDX_W'(VOICES - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_DRAIN;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					if (!rd_v_s1 && !wv_busy) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || smp.ready) begin
						out_valid_q <= 1'b1;
						if (acc_ext > 32'sd65535) begin
							out_sample_q <= SAMPLE_W'(SAMPLE_MAX);
						end else if (acc_ext < -32'sd65536) begin
							out_sample_q <= SAMPLE_W'(SAMPLE_MIN);
						end else begin
							out_sample_q <= SAMPLE_W'(acc_ext);
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign smp.valid        = out_valid_q;
	assign smp.mixed_sample = out_sample_q;

	// a new sample word only comes out of the DONE step
	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("sample word raised outside DONE");

	// voice configuration never changes while a tick walks the memories
	a_no_cfg_in_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !cfg_we && !stop_we)
		else $error("voice config written during a tick");

	// a tick starts from an empty accumulator
	a_acc_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_fire && (cmd.opcode == OP_TICK)) |=> (acc_q == '0))
		else $error("accumulator not cleared at tick start");

	// wave results only arrive while a tick is in flight
	a_wave_in_tick: assert property (@(posedge clk) disable iff (!arst_n)
		wout.valid |-> (state_q == ST_RUN || state_q == ST_DRAIN))
		else $error("wave result outside a tick");

endmodule

@@ design/mvws_wave.sv @@
// Wave datapath: turns one voice visit (phase, waveform, on) into a scaled Q1.15 value.
// Six register stages; holds the shared noise LFSR. Depends on mvws_pkg.
module mvws_wave
	import mvws_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  voice_in_t vin,
	output wave_out_t wout,
	output logic      busy
);

	// ---- stage 1: decode phase, simple waves, noise ----
	logic [15:0]          lfsr_q;
	logic [15:0]          lfsr_nxt;
	logic                 noise_adv;
	logic [15:0]          t_c;
	logic [1:0]           quad_c;
	logic [14:0]          x_c;
	logic [PHASE_BITS+15:0] saw_w;
	logic [PHASE_BITS:0]  two_c;
	logic [PHASE_BITS:0]  dist_c;
	logic [PHASE_BITS+16:0] tri_w;
	logic [16:0]          tri_b;
	logic signed [15:0]   other_c;
	logic                 sine_c;

	always_comb begin
		lfsr_nxt = {1'b0, lfsr_q[15:1]};
		if (lfsr_q[0]) begin
			lfsr_nxt = lfsr_nxt ^ LFSR_TAPS;
		end
	end

	assign noise_adv = vin.valid && vin.on && (vin.wave == WAVE_NOISE);

	always_comb begin
		t_c    = 16'({vin.phase[PHASE_BITS-1 -: SINE_BITS], 16'b0} >> SINE_BITS);
		quad_c = t_c[15:14];
		x_c    = quad_c[0] ? 15'(QTR_TURN - int'(t_c[13:0])) : {1'b0, t_c[13:0]};

		saw_w  = {vin.phase, 16'b0};
		two_c  = {vin.phase, 1'b0};
		dist_c = vin.phase[PHASE_BITS-1] ? (two_c - {1'b1, {PHASE_BITS{1'b0}}})
		                                 : ({1'b1, {PHASE_BITS{1'b0}}} - two_c);
		tri_w  = {dist_c, 16'b0};
		tri_b  = tri_w[PHASE_BITS+16:PHASE_BITS];

		sine_c  = 1'b0;
		other_c = '0;
		if (vin.on) begin
			unique case (vin.wave)
				WAVE_SINE:     sine_c = 1'b1;
				WAVE_SQUARE:   other_c = vin.phase[PHASE_BITS-1] ? -16'sd32768 : 16'sd32767;
				WAVE_TRIANGLE: other_c = tri_b[16] ? 16'sd32767 : {~tri_b[15], tri_b[14:0]};
				WAVE_SAW: begin
					other_c = {~saw_w[PHASE_BITS+15], saw_w[PHASE_BITS+14 -: 15]};
				end
				WAVE_NOISE:    other_c = {~lfsr_nxt[15], lfsr_nxt[14:0]};
				default:       other_c = '0;
			endcase
		end
	end

	// ---- stage registers ----
	logic               v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic               sine_s2, sine_s3, sine_s4, sine_s5;
	logic               neg_s2, neg_s3, neg_s4, neg_s5;
	logic signed [15:0] oth_s2, oth_s3, oth_s4, oth_s5;
	logic [14:0]        x_s2, x_s3, x_s4, x_s5;
	logic [14:0]        x2_s3, x2_s4;
	logic [13:0]        inner_s4;
	logic [14:0]        mid_s5;
	logic signed [15:0] val_s6;
	logic signed [SCALED_W-1:0] scaled_s7;

	logic [29:0]        xx_c;
	logic [25:0]        c3_c;
	logic [28:0]        mx_c;
	logic [29:0]        y_c;
	logic [16:0]        y2_c;
	logic [15:0]        ysat_c;
	logic signed [15:0] val_c;
	logic signed [30:0] prod_c;

	always_comb begin
		xx_c   = 30'(x_s2) * 30'(x_s2);
		c3_c   = 26'(x2_s3) * 26'(SIN_C3);
		mx_c   = 29'(x2_s4) * 29'(inner_s4);
		y_c    = 30'(x_s5) * 30'(mid_s5);
		y2_c   = {16'(y_c >> 14), 1'b0};
		ysat_c = (y2_c > 17'd32767) ? 16'd32767 : y2_c[15:0];
		val_c  = sine_s5 ? (neg_s5 ? -$signed(ysat_c) : $signed(ysat_c)) : oth_s5;
		prod_c = 31'(val_s6) * 31'(GAIN_Q15);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lfsr_q <= LFSR_SEED;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			v_s5   <= 1'b0;
			v_s6   <= 1'b0;
			v_s7   <= 1'b0;
		end else begin
			if (noise_adv) begin
				lfsr_q <= lfsr_nxt;
			end
			v_s2 <= vin.valid;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		sine_s2 <= sine_c;
		neg_s2  <= quad_c[1];
		oth_s2  <= other_c;
		x_s2    <= x_c;

		sine_s3 <= sine_s2;
		neg_s3  <= neg_s2;
		oth_s3  <= oth_s2;
		x_s3    <= x_s2;
		x2_s3   <= 15'(xx_c >> 14);

		sine_s4  <= sine_s3;
		neg_s4   <= neg_s3;
		oth_s4   <= oth_s3;
		x_s4     <= x_s3;
		x2_s4    <= x2_s3;
		inner_s4 <= 14'(26'(SIN_C2) - (c3_c >> 14));

		sine_s5 <= sine_s4;
		neg_s5  <= neg_s4;
		oth_s5  <= oth_s4;
		x_s5    <= x_s4;
		mid_s5  <= 15'(29'(SIN_C1) - (mx_c >> 14));

		val_s6    <= val_c;
		scaled_s7 <= SCALED_W'((prod_c + 31'(SCALE_RND)) >>> 15);
	end

	assign wout.valid  = v_s7;
	assign wout.scaled = scaled_s7;
	assign busy        = v_s2 | v_s3 | v_s4 | v_s5 | v_s6 | v_s7;

endmodule
